>>> hw/rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, register indexes and the segment table shared by the down counter
// and its display writer.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int unsigned COUNT_W = 28;
  localparam int unsigned START_W = 27;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_VALUE = 2'd0,
    REG_FLOOR_VALUE = 2'd1,
    REG_STEP_SIZE   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic switch_on;
    logic reload;
  } in_item_t;

  typedef struct packed {
    logic [2:0] digit_position;
    logic [7:0] segment_code;
    logic       last_digit;
  } out_item_t;

  // Write side of the queue between the counter and the display writer.
  typedef struct packed {
    logic               push;
    logic [START_W-1:0] value;
  } queue_wr_t;

  // Read side of the queue.
  typedef struct packed {
    logic               empty;
    logic [START_W-1:0] head;
  } queue_rd_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'd252;
      4'd1: code = 8'd96;
      4'd2: code = 8'd218;
      4'd3: code = 8'd242;
      4'd4: code = 8'd102;
      4'd5: code = 8'd182;
      4'd6: code = 8'd190;
      4'd7: code = 8'd224;
      4'd8: code = 8'd254;
      4'd9: code = 8'd246;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/step_down_counter_seven_segment.sv
// ----------------------------------------------------------------------------
// step_down_counter_seven_segment
// Signed down counter whose positive values are written out as decimal digits
// for a seven-segment display.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                        Transfer carries
//  in        sink       in_valid, in_ready, in_data    one poll (switch, reload)
//  out       source     out_valid, out_ready, out_data one digit write
//  cfg       sink       cfg_valid, cfg_ready, cfg_*    one register write
//
// A poll updates the counter in the cycle of its transfer; polls are taken one
// per cycle while the two-entry queue has room.
// The display writer produces one digit per cycle unless out stalls, with the
// single divide-by-ten unit; a positive count gives DIGIT_COUNT digit writes.
// A poll that leaves the count at zero or below produces no transfer on out.
// Reset clears the counter and loads the register defaults; cfg is always ready.
// ----------------------------------------------------------------------------
module step_down_counter_seven_segment #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sdc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sdc_pkg::out_item_t             out_data
);

  sdc_pkg::queue_wr_t queue_wr;
  sdc_pkg::queue_rd_t queue_rd;
  logic               queue_full;
  logic               pop;

  sdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .queue_wr   (queue_wr)
  );

  sdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .queue_wr (queue_wr),
    .pop      (pop),
    .full     (queue_full),
    .queue_rd (queue_rd)
  );

  sdc_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .queue_rd  (queue_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/sdc_front.sv
// ----------------------------------------------------------------------------
// sdc_front
// Holds the configuration registers and the counter. Each poll updates the
// counter in the cycle it is accepted and queues a positive value for display.
// ----------------------------------------------------------------------------
module sdc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sdc_pkg::in_item_t            in_data,
  input  logic                         queue_full,
  output sdc_pkg::queue_wr_t           queue_wr
);

  logic [sdc_pkg::START_W-1:0]        start_value;
  logic signed [sdc_pkg::COUNT_W-1:0] floor_value;
  logic [sdc_pkg::STEP_W-1:0]         step_size;
  logic signed [sdc_pkg::COUNT_W-1:0] count_value;
  logic signed [sdc_pkg::COUNT_W-1:0] count_value_next;
  logic signed [sdc_pkg::COUNT_W-1:0] base;
  logic signed [sdc_pkg::COUNT_W:0]   diff;
  logic                               accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    base = in_data.reload ? $signed({1'b0, start_value}) : count_value;
    diff = {base[sdc_pkg::COUNT_W-1], base}
         - $signed({{(sdc_pkg::COUNT_W+1-sdc_pkg::STEP_W){1'b0}}, step_size});
    count_value_next = base;
    // The step is taken only if the counter stays at or above the floor.
    if (in_data.switch_on && (diff >= $signed({floor_value[sdc_pkg::COUNT_W-1], floor_value}))) begin
      count_value_next = diff[sdc_pkg::COUNT_W-1:0];
    end
  end

  assign queue_wr.push  = accept && !count_value_next[sdc_pkg::COUNT_W-1]
                          && (count_value_next != '0);
  assign queue_wr.value = count_value_next[sdc_pkg::START_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
      floor_value <= '0;
      step_size   <= sdc_pkg::STEP_W'(3);
      count_value <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdc_pkg::REG_START_VALUE: start_value <= cfg_data[sdc_pkg::START_W-1:0];
          sdc_pkg::REG_FLOOR_VALUE: floor_value <= cfg_data[sdc_pkg::COUNT_W-1:0];
          sdc_pkg::REG_STEP_SIZE:   step_size   <= cfg_data[sdc_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        count_value <= count_value_next;
      end
    end
  end

endmodule

>>> hw/rtl/sdc_queue.sv
// ----------------------------------------------------------------------------
// sdc_queue
// Two-entry queue of counter values waiting to be written to the display.
// ----------------------------------------------------------------------------
module sdc_queue (
  input  logic               clk,
  input  logic               rst,
  input  sdc_pkg::queue_wr_t queue_wr,
  input  logic               pop,
  output logic               full,
  output sdc_pkg::queue_rd_t queue_rd
);

  logic [sdc_pkg::START_W-1:0] entry [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic                        do_push;
  logic                        do_pop;

  assign full           = (fill == 2'd2);
  assign queue_rd.empty = (fill == 2'd0);
  assign queue_rd.head  = entry[rd_ptr];
  assign do_push        = queue_wr.push && !full;
  assign do_pop         = pop && !queue_rd.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= queue_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hw/rtl/sdc_back.sv
// ----------------------------------------------------------------------------
// sdc_back
// Display writer: splits a queued value into decimal digits, one per cycle unless
// out stalls, least significant first, and presents each through an output register.
// ----------------------------------------------------------------------------
module sdc_back #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  sdc_pkg::queue_rd_t queue_rd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sdc_pkg::out_item_t out_data
);

  localparam logic [2:0] LAST_POS = 3'(DIGIT_COUNT - 1);
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  logic                        busy;
  logic [sdc_pkg::START_W-1:0] rest;
  logic [2:0]                  pos;
  logic [58:0]                 product;
  logic [sdc_pkg::START_W-1:0] quot;
  logic [3:0]                  digit;
  logic                        advance;
  logic                        finishing;

  // Division by ten through the reciprocal; exact for any 27-bit dividend.
  assign product = {32'd0, rest} * {27'd0, RECIP_10};
  assign quot    = product[35 +: sdc_pkg::START_W];
  assign digit   = rest[3:0] - (quot[3:0] << 3) - (quot[3:0] << 1);

  assign advance   = busy && (!out_valid || out_ready);
  assign finishing = advance && (pos == LAST_POS);
  assign pop       = (!busy || finishing) && !queue_rd.empty;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.digit_position <= pos;
      out_data.segment_code   <= sdc_pkg::seg_code(digit);
      out_data.last_digit     <= (pos == LAST_POS);
    end
    if (pop) begin
      rest <= queue_rd.head;
      pos  <= 3'd0;
    end else if (advance) begin
      rest <= quot;
      pos  <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks on the digit writes of the down counter display.
// ----------------------------------------------------------------------------
module sdc_checker #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input sdc_pkg::out_item_t             out_data
);

  localparam logic [2:0] LAST_POS = 3'(DIGIT_COUNT - 1);

  // A stalled digit write must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digit write changed while stalled");

  // The run ends exactly at the top display position.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_digit == (out_data.digit_position == LAST_POS)))
    else $error("last digit flag does not match position");

  // Every write carries a nonzero segment code with bit 0 clear.
  a_seg_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.segment_code != 8'd0 && !out_data.segment_code[0])
    else $error("segment code is not a decimal digit");

  // A transfer that is not the last of its run is followed by the next position.
  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_digit |=>
      !out_valid || out_data.digit_position == $past(out_data.digit_position) + 3'd1)
    else $error("digit positions out of order");

  // Reset leaves no write pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("digit write pending after reset");

endmodule

bind step_down_counter_seven_segment sdc_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_sdc_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the step down counter and its eight-digit display
// writer. Polls and register writes are driven over their handshakes, every
// accepted poll is run through a local model of the counter, and each digit
// write that comes out is compared with the oldest one still due.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdc_pkg::*;

  localparam int DIGITS        = 8;
  localparam int SETTLE_CYCLES = 3 * DIGITS + 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  step_down_counter_seven_segment #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Local copy of the counter and its registers.
  logic signed [COUNT_W-1:0] counter_value;
  logic [START_W-1:0]        start_reg;
  logic signed [COUNT_W-1:0] final_reg;
  logic [STEP_W-1:0]         step_reg;
  logic [7:0] seg_pattern [10] = '{8'd252, 8'd96, 8'd218, 8'd242, 8'd102,
                                   8'd182, 8'd190, 8'd224, 8'd254, 8'd246};

  out_item_t digit_writes_due [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        polls_sent = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic predict_poll(input in_item_t item);
    int          next_count;
    logic [31:0] next_bits;
    logic [26:0] rest;
    out_item_t   due;
    if (item.reload)
      counter_value = signed'({1'b0, start_reg});
    if (item.switch_on) begin
      next_count = int'(counter_value) - int'(step_reg);
      // The step is dropped whenever it would take the count under the floor.
      if (next_count >= int'(final_reg)) begin
        next_bits     = next_count;
        counter_value = next_bits[COUNT_W-1:0];
      end
    end
    if (counter_value > 0) begin
      rest = counter_value[26:0];
      for (int k = 0; k < DIGITS; k++) begin
        due.digit_position = k[2:0];
        due.segment_code   = seg_pattern[rest % 10];
        due.last_digit     = (k == DIGITS - 1);
        rest               = rest / 10;
        digit_writes_due.push_back(due);
      end
    end
  endtask

  task automatic check_digit_write(input out_item_t got);
    out_item_t due;
    if (digit_writes_due.size() == 0) begin
      report_mismatch("digit write with none due, position", int'(got.digit_position), -1);
    end else begin
      due = digit_writes_due.pop_front();
      if (got.digit_position !== due.digit_position)
        report_mismatch("digit_position", int'(got.digit_position),
                        int'(due.digit_position));
      if (got.segment_code !== due.segment_code)
        report_mismatch("segment_code", int'(got.segment_code), int'(due.segment_code));
      if (got.last_digit !== due.last_digit)
        report_mismatch("last_digit", int'(got.last_digit), int'(due.last_digit));
    end
  endtask

  // One process watches all three channels, so a poll is always modelled
  // before any digit write of the same edge is checked.
  always @(posedge clk) begin
    if (rst) begin
      counter_value = '0;
      start_reg     = '0;
      final_reg     = '0;
      step_reg      = 4'd3;
      digit_writes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_VALUE: start_reg = cfg_data[START_W-1:0];
          REG_FLOOR_VALUE: final_reg = signed'(cfg_data);
          REG_STEP_SIZE:   step_reg  = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_poll(in_data);
      if (out_valid && out_ready)
        check_digit_write(out_data);
    end
  end

  // Leaves valid high so that a following write can go out back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] start_data,
                               input logic [CFG_DATA_W-1:0] final_data,
                               input logic [CFG_DATA_W-1:0] step_data);
    write_reg(REG_START_VALUE, start_data);
    write_reg(REG_FLOOR_VALUE, final_data);
    write_reg(REG_STEP_SIZE, step_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_poll(input logic switch_on, input logic reload);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.switch_on <= switch_on;
    in_data.reload    <= reload;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
  endtask

  // Registers may only change once the display writer has gone quiet; a poll
  // that yields no digits gives no sign of its end, hence the extra cycles.
  // The first edge lets the last accepted poll reach the model.
  task automatic wait_display_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digit_writes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    wait_display_idle();
    send_poll(1'b1, 1'b0);
    send_poll(1'b0, 1'b1);
    // Only start_value changes, so the default step of three is used.
    wait_display_idle();
    write_reg(REG_START_VALUE, 28'd10);
    cfg_valid <= 1'b0;
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b0);
  endtask

  task automatic test_digit_extremes();
    wait_display_idle();
    set_registers(28'd99999999, -28'sd99999999, 28'd15);
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b0);
    // All ones in start and step, the floor at its most negative: the start value exceeds eight digits.
    wait_display_idle();
    set_registers(28'hFFFFFFF, 28'h8000000, 28'hFFFFFFF);
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b0);
  endtask

  task automatic test_zero_step();
    wait_display_idle();
    set_registers(28'd4321, 28'd0, 28'd0);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b0);
  endtask

  task automatic test_step_blocked();
    wait_display_idle();
    set_registers(28'd1, 28'd0, 28'd1);
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b0);
    send_poll(1'b1, 1'b0);
    wait_display_idle();
    set_registers(28'd99999999, 28'd99999999, 28'd5);
    send_poll(1'b1, 1'b1);
  endtask

  task automatic test_negative_floor();
    wait_display_idle();
    set_registers(28'd5, 28'h8000000, 28'd15);
    send_poll(1'b1, 1'b1);
    send_poll(1'b1, 1'b0);
  endtask

  task automatic test_unknown_index();
    wait_display_idle();
    write_reg(REG_UNUSED, 28'hFFFFFFF);
    cfg_valid <= 1'b0;
    send_poll(1'b0, 1'b1);
    send_poll(1'b1, 1'b0);
  endtask

  task automatic run_counting_sequence();
    logic [START_W-1:0]    start_v;
    logic [STEP_W-1:0]     step_v;
    logic [31:0]           noise_bits;
    logic [31:0]           final_bits;
    logic [CFG_DATA_W-1:0] start_data;
    logic [CFG_DATA_W-1:0] step_data;
    int                    final_v;
    int                    pick;
    int                    run_len;
    pick = $urandom_range(9);
    if (pick < 5)
      start_v = START_W'($urandom_range(60));
    else if (pick < 9)
      start_v = START_W'($urandom_range(99999999));
    else
      start_v = START_W'($urandom_range(134217727));
    pick = $urandom_range(9);
    if (pick < 7)
      final_v = int'(start_v) - int'($urandom_range(90));
    else if (pick < 9)
      final_v = int'($urandom_range(199999998)) - 99999999;
    else
      final_v = $urandom_range(1) ? 99999999 : -99999999;
    final_bits = final_v;
    step_v     = STEP_W'($urandom_range(15));
    noise_bits = $urandom();
    // Now and then the unused upper bits of a write carry junk.
    start_data = {($urandom_range(7) == 0) ? noise_bits[31] : 1'b0, start_v};
    step_data  = {($urandom_range(3) == 0) ? noise_bits[23:0] : 24'd0, step_v};
    wait_display_idle();
    set_registers(start_data, final_bits[CFG_DATA_W-1:0], step_data);
    send_poll(1'(($urandom_range(1))), 1'b1);
    run_len = $urandom_range(4, 14);
    repeat (run_len)
      send_poll($urandom_range(9) != 0, $urandom_range(19) == 0);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
    int stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at        = polls_sent + count;
    while (polls_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_poll(1'(($urandom_range(1))), 1'(($urandom_range(1))));
      end else begin
        run_counting_sequence();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_digit_extremes();
    test_zero_step();
    test_step_blocked();
    test_negative_floor();
    test_unknown_index();
    test_random_phase(0, 0, 95);
    test_random_phase(74, 0, 95);
    test_random_phase(0, 74, 95);
    test_random_phase(32, 32, 95);
    wait_display_idle();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
